/* hdl/twg_pkg.sv */
package twg_pkg;

	// Fixed-point format and internal widths
	localparam int FRAC_BITS  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int NUM_W      = 64;
	localparam int DIV_W      = 34;

	localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

	// Configuration register indexes
	localparam logic [2:0] REG_START  = 3'd0;
	localparam logic [2:0] REG_FINISH = 3'd1;
	localparam logic [2:0] REG_PERIOD = 3'd2;
	localparam logic [2:0] REG_PHASE  = 3'd3;
	localparam logic [2:0] REG_AMPL   = 3'd4;
	localparam logic [2:0] REG_LEVEL  = 3'd5;

	// Section of the wave period that a sample falls in
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_FALL,
		SEG_TAIL
	} seg_t;

	// Per-sample context carried alongside a division
	typedef struct packed {
		logic               in_win;
		logic signed [31:0] t;
		logic               neg;
		seg_t               seg;
	} ctx_t;

	// One transaction moving through a divider chain
	typedef struct packed {
		logic             vld;
		logic [NUM_W-1:0] nq;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] d;
		ctx_t             ctx;
	} div_t;

endpackage

/* hdl/windowed_triangle_wave_core.sv */
// Windowed triangle wave: one signed Q16.16 sample_time in, one wave_value and
// in_window flag out per transaction. The core accepts one sample per clock cycle;
// each result passes through three bit-per-cell divider chains of 64 cells each
// (phase shift, period modulo, slope scaling) plus six pipeline registers. The
// whole pipeline advances together, so it stalls only while a result waits at the
// output and out_ready is low. Configuration registers must be written only while
// no transaction is in flight.
module windowed_triangle_wave_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] wave_value,
	output logic        in_window,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import twg_pkg::*;

	localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

	logic signed [31:0] start_q, finish_q, phase_q, ampl_q, level_q;
	logic [30:0]        period_q;

	logic               en;
	logic               vld_s1;
	logic signed [31:0] t_s1;
	div_t               s2, c1, s3, c2, s5, c3;
	logic               vld_s4, in_win_s4;
	logic [32:0]        k_s4;
	seg_t               seg_s4;

	logic               out_valid_q, in_window_q;
	logic [31:0]        wave_value_q;

	logic [31:0]        p_eff, z_mag, a_mag, r_v, pos_v;
	logic [33:0]        p34, p3, q4, sub_v;
	logic signed [63:0] shift_v, x_v;
	logic [64:0]        prod_v;
	logic signed [35:0] tr_v, a36, z36, v_v, sat_v;
	seg_t               seg_v;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			finish_q <= '0;
			period_q <= 31'(ONE_Q);
			phase_q  <= '0;
			ampl_q   <= signed'(ONE_Q);
			level_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_data;
				REG_FINISH: finish_q <= cfg_data;
				REG_PERIOD: period_q <= cfg_data[30:0];
				REG_PHASE:  phase_q  <= cfg_data;
				REG_AMPL:   ampl_q   <= cfg_data;
				REG_LEVEL:  level_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived configuration values
	always_comb begin
		p_eff = (period_q == '0) ? ONE_Q : {1'b0, period_q};
		z_mag = level_q[31] ? 32'(-level_q) : 32'(level_q);
		a_mag = ampl_q[31] ? 32'(-ampl_q) : 32'(ampl_q);
		p34   = 34'(p_eff);
		p3    = 34'(p34 * 34'd3);
		a36   = 36'(ampl_q);
		z36   = 36'(level_q);
	end

	// The pipeline moves as a whole whenever the output register can take a result.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s4 <= c2.vld;
		end
	end

	// Stage 1 captures the sample; stage 2 forms |Z| * P for the phase shift division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1 <= '0;
			s2   <= '0;
		end else if (en) begin
			t_s1           <= sample_time;
			s2.vld         <= vld_s1;
			s2.nq          <= 64'(z_mag) * 64'(p_eff);
			s2.rem         <= '0;
			s2.d           <= {a_mag, 2'b00};
			s2.ctx.in_win  <= (start_q <= t_s1) && (t_s1 <= finish_q);
			s2.ctx.t       <= t_s1;
			s2.ctx.neg     <= level_q[31] ^ ampl_q[31];
			s2.ctx.seg     <= SEG_RISE;
		end
	end

	twg_div_chain u_shift_div (
		.clk (clk), .arst_n (arst_n), .en (en), .din (s2), .dout (c1)
	);

	// Shifted time, split into magnitude and sign for the period modulo.
	always_comb begin
		shift_v = c1.ctx.neg ? -signed'(c1.nq) : signed'(c1.nq);
		x_v     = 64'(c1.ctx.t) + 64'(phase_q) - shift_v - 64'(start_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3 <= '0;
		end else if (en) begin
			s3.vld        <= c1.vld;
			s3.nq         <= x_v[63] ? 64'(-x_v) : 64'(x_v);
			s3.rem        <= '0;
			s3.d          <= p34;
			s3.ctx.in_win <= c1.ctx.in_win;
			s3.ctx.t      <= c1.ctx.t;
			s3.ctx.neg    <= x_v[63];
			s3.ctx.seg    <= SEG_RISE;
		end
	end

	twg_div_chain u_mod_div (
		.clk (clk), .arst_n (arst_n), .en (en), .din (s3), .dout (c2)
	);

	// Floor modulo position, then pick the section of the period.
	always_comb begin
		r_v   = c2.rem[31:0];
		pos_v = (c2.ctx.neg && (r_v != '0)) ? (p_eff - r_v) : r_v;
		q4    = {pos_v, 2'b00};
		if (q4 < p34) begin
			seg_v = SEG_RISE;
			sub_v = '0;
		end else if (q4 < p3) begin
			seg_v = SEG_FALL;
			sub_v = p34;
		end else begin
			seg_v = SEG_TAIL;
			sub_v = p3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s4      <= 33'(q4 - sub_v);
			seg_s4    <= seg_v;
			in_win_s4 <= c2.ctx.in_win;
		end
	end

	// Scale the position within the section by |A|.
	assign prod_v = 65'(a_mag) * 65'(k_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s5 <= '0;
		end else if (en) begin
			s5.vld        <= vld_s4;
			s5.nq         <= prod_v[63:0];
			s5.rem        <= '0;
			s5.d          <= p34;
			s5.ctx.in_win <= in_win_s4;
			s5.ctx.t      <= '0;
			s5.ctx.neg    <= ampl_q[31];
			s5.ctx.seg    <= seg_s4;
		end
	end

	twg_div_chain u_slope_div (
		.clk (clk), .arst_n (arst_n), .en (en), .din (s5), .dout (c3)
	);

	// Combine the section value with the level offset and saturate.
	always_comb begin
		tr_v = c3.ctx.neg ? -signed'(36'(c3.nq[33:0])) : signed'(36'(c3.nq[33:0]));
		unique case (c3.ctx.seg)
			SEG_RISE: v_v = tr_v + z36;
			SEG_FALL: v_v = a36 - tr_v + z36;
			SEG_TAIL: v_v = tr_v - a36 + z36;
			default:  v_v = z36;
		endcase
		if (ampl_q == '0) begin
			v_v = z36;
		end
		if (v_v > SAT_MAX) begin
			sat_v = SAT_MAX;
		end else if (v_v < SAT_MIN) begin
			sat_v = SAT_MIN;
		end else begin
			sat_v = v_v;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wave_value_q <= c3.ctx.in_win ? sat_v[31:0] : '0;
			in_window_q  <= c3.ctx.in_win;
		end
	end

	assign out_valid  = out_valid_q;
	assign wave_value = wave_value_q;
	assign in_window  = in_window_q;

	// A waiting result must hold off new transactions.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// Samples outside the window always read as zero.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_window |-> wave_value == '0)
		else $error("nonzero sample outside window");

	// With zero amplitude the wave is flat at the level offset.
	a_flat_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_window && (ampl_q == '0) |-> wave_value == level_q)
		else $error("flat wave does not match level offset");

endmodule

/* hdl/twg_div_cell.sv */
module twg_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  twg_pkg::div_t  din,
	output twg_pkg::div_t  dout
);
	import twg_pkg::*;

	logic [DIV_W:0] trial;
	logic           ge;
	div_t           nxt;
	logic           vld_q;
	div_t           data_q;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		trial   = {din.rem, din.nq[NUM_W-1]};
		ge      = trial >= {1'b0, din.d};
		nxt     = din;
		nxt.nq  = {din.nq[NUM_W-2:0], ge};
		nxt.rem = ge ? DIV_W'(trial - {1'b0, din.d}) : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

/* hdl/twg_div_chain.sv */
module twg_div_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  twg_pkg::div_t  din,
	output twg_pkg::div_t  dout
);
	import twg_pkg::*;

	div_t link [NUM_W+1];

	assign link[0] = din;

	// One cell per quotient bit, most significant first.
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		twg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign dout = link[NUM_W];

endmodule
